// ----- sv/ultrasonic_obstacle_drive_controller_core_macros.svh -----
// Assertion helpers shared by the core's modules.
// Each expects clk and rst_n in the enclosing module.
`ifndef ULTRASONIC_OBSTACLE_DRIVE_CONTROLLER_CORE_MACROS_SVH
`define ULTRASONIC_OBSTACLE_DRIVE_CONTROLLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define UODC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define UODC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/uodc_pkg.sv -----
package uodc_pkg;

    // Field and state widths
    localparam int CH_NUM    = 4;
    localparam int CH_IDX_W  = 2;
    localparam int DIST_W    = 16;
    localparam int SUM_W     = 20;
    localparam int CNT_W     = 4;
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int SAMPLES_DEFAULT  = 10;
    localparam int MAX_BODY_DEFAULT = 19;

    // Link byte codes
    localparam logic [BYTE_W-1:0] BYTE_START = 8'h53;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h45;
    localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;
    localparam logic [LEN_W-1:0]  MIN_BODY   = 5'd3;

    // Limit register reset values
    localparam logic [DIST_W-1:0] FRONT_LIMIT_RST      = 16'd30;
    localparam logic [DIST_W-1:0] SIDE_LIMIT_RST       = 16'd45;
    localparam logic [DIST_W-1:0] REAR_CLEAR_LIMIT_RST = 16'd20;
    localparam logic [DIST_W-1:0] REAR_STOP_LIMIT_RST  = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_LIMIT      = 2'd0,
        CFG_SIDE_LIMIT       = 2'd1,
        CFG_REAR_CLEAR_LIMIT = 2'd2,
        CFG_REAR_STOP_LIMIT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1
    } parse_phase_t;

    typedef enum logic [1:0] {
        DS_FORWARD = 2'd0,
        DS_STOP    = 2'd1,
        DS_REVERSE = 2'd2
    } drive_state_t;

    typedef enum logic [1:0] {
        M_NONE    = 2'd0,
        M_FORWARD = 2'd1,
        M_STOP    = 2'd2,
        M_REVERSE = 2'd3
    } motor_cmd_t;

    typedef enum logic [1:0] {
        S_NONE     = 2'd0,
        S_STRAIGHT = 2'd1,
        S_LEFT     = 2'd2,
        S_RIGHT    = 2'd3
    } servo_cmd_t;

    typedef logic [DIST_W-1:0] dist_t;
    typedef dist_t [CH_NUM-1:0] dist_arr_t;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  motor_cmd;
        logic [1:0]  servo_cmd;
        logic [1:0]  drive_mode;
        logic        obstacle_near;
        dist_t       front_cm;
        dist_t       side_one_cm;
        dist_t       side_two_cm;
        dist_t       rear_cm;
    } out_word_t;

    // Completed frame handed from parser to averager
    typedef struct packed {
        logic                valid;
        logic [CH_IDX_W-1:0] chan;
        dist_t               value;
    } frame_t;

    typedef struct packed {
        dist_t front_limit;
        dist_t side_limit;
        dist_t rear_clear_limit;
        dist_t rear_stop_limit;
    } limits_t;

    typedef struct packed {
        logic [1:0] motor_cmd;
        logic [1:0] servo_cmd;
        logic [1:0] drive_mode;
        logic       obstacle_near;
    } decision_t;

endpackage

// ----- sv/uodc_parser.sv -----
`include "ultrasonic_obstacle_drive_controller_core_macros.svh"

module uodc_parser #(
    parameter int MAX_FRAME_BODY = uodc_pkg::MAX_BODY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [uodc_pkg::BYTE_W-1:0]   rx_byte,
    output uodc_pkg::frame_t              frame
);
    import uodc_pkg::*;

    parse_phase_t       phase_reg, phase_next;
    logic [LEN_W-1:0]   body_len_reg, body_len_next;
    logic [BYTE_W-1:0]  chan_reg, chan_next;
    dist_t              value_reg, value_next;
    logic               ended_reg, ended_next;

    logic [LEN_W-1:0]   len_inc;
    logic               is_start, is_end, is_digit, too_long, chan_ok;
    logic [3:0]         digit;
    logic [SUM_W-1:0]   value_wide;
    logic [BYTE_W-1:0]  chan_off;

    assign len_inc    = body_len_reg + LEN_W'(1);
    assign is_start   = (rx_byte == BYTE_START);
    assign is_end     = (rx_byte == BYTE_END);
    assign is_digit   = (rx_byte >= BYTE_ZERO) && (rx_byte <= BYTE_ZERO + 8'd9);
    assign too_long   = (len_inc >= LEN_W'(MAX_FRAME_BODY));
    assign chan_ok    = (chan_reg >= BYTE_ZERO + 8'd1) && (chan_reg <= BYTE_ZERO + 8'd4);
    assign chan_off   = chan_reg - (BYTE_ZERO + 8'd1);

    // value * 10 + digit
    assign digit      = 4'(rx_byte - BYTE_ZERO);
    assign value_wide = SUM_W'({value_reg, 3'b000}) + SUM_W'({value_reg, 1'b0})
                      + SUM_W'(digit);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (is_start)
                        phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    if (is_end || too_long)
                        phase_next = PH_HUNT;
                end
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    // Frame fields and completed frame
    always_comb
    begin
        body_len_next = body_len_reg;
        chan_next     = chan_reg;
        value_next    = value_reg;
        ended_next    = ended_reg;
        frame.valid   = 1'b0;
        frame.chan    = chan_off[CH_IDX_W-1:0];
        frame.value   = value_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (is_start)
                    begin
                        body_len_next = '0;
                        chan_next     = '0;
                        value_next    = '0;
                        ended_next    = 1'b0;
                    end
                end
                PH_BODY:
                begin
                    body_len_next = len_inc;
                    if (is_end)
                    begin
                        frame.valid = (len_inc >= MIN_BODY) && chan_ok;
                    end
                    else if (body_len_reg == LEN_W'(0))
                    begin
                        chan_next = rx_byte;
                    end
                    else if (body_len_reg == LEN_W'(1))
                    begin
                        // NUL separator voids the channel
                        if (rx_byte == BYTE_NUL)
                            chan_next = '0;
                    end
                    else if (!ended_reg)
                    begin
                        if (is_digit)
                            value_next = (|value_wide[SUM_W-1:DIST_W]) ? '1
                                       : value_wide[DIST_W-1:0];
                        else
                            ended_next = 1'b1;
                    end
                end
                default:
                begin
                    body_len_next = body_len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            body_len_reg <= '0;
            chan_reg     <= '0;
            value_reg    <= '0;
            ended_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            body_len_reg <= body_len_next;
            chan_reg     <= chan_next;
            value_reg    <= value_next;
            ended_reg    <= ended_next;
        end
    end

    `UODC_ASSERT_SAME(a_body_len_bound, phase_reg == PH_BODY, body_len_reg < LEN_W'(MAX_FRAME_BODY), "frame body ran past its limit")

endmodule

// ----- sv/uodc_avg.sv -----
`include "ultrasonic_obstacle_drive_controller_core_macros.svh"

module uodc_avg #(
    parameter int SAMPLES_PER_AVERAGE = uodc_pkg::SAMPLES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  uodc_pkg::frame_t    frame,
    output uodc_pkg::dist_arr_t avg_dist
);
    import uodc_pkg::*;

    // Reciprocal for sum / SAMPLES_PER_AVERAGE, exact for any SUM_W-bit sum
    localparam int          DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam longint      DIV_MULT  = ((64'd1 <<< DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1)
                                      / SAMPLES_PER_AVERAGE;
    localparam int          MULT_W    = SUM_W + 2;
    localparam int          PROD_W    = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] RECIP = MULT_W'(DIV_MULT);

    logic [CNT_W-1:0] count_reg [CH_NUM];
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] sum_reg   [CH_NUM];
    logic [SUM_W-1:0] sum_next;
    dist_t            avg_reg   [CH_NUM];
    dist_t            avg_next;

    logic [CNT_W-1:0] sel_count;
    logic [SUM_W-1:0] sel_sum;
    logic [PROD_W-1:0] prod;
    logic             full;

    assign sel_count = count_reg[frame.chan];
    assign sel_sum   = sum_reg[frame.chan];
    assign full      = (sel_count >= CNT_W'(SAMPLES_PER_AVERAGE));
    assign prod      = PROD_W'(sel_sum) * PROD_W'(RECIP);

    // Accumulate, or close the average on the frame after a full set
    always_comb
    begin
        if (full)
        begin
            count_next = '0;
            sum_next   = '0;
            avg_next   = prod[DIV_SHIFT +: DIST_W];
        end
        else
        begin
            count_next = sel_count + CNT_W'(1);
            sum_next   = sel_sum + SUM_W'(frame.value);
            avg_next   = avg_reg[frame.chan];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_NUM; i++)
            begin
                count_reg[i] <= '0;
                sum_reg[i]   <= '0;
                avg_reg[i]   <= '0;
            end
        end
        else if (frame.valid)
        begin
            count_reg[frame.chan] <= count_next;
            sum_reg[frame.chan]   <= sum_next;
            avg_reg[frame.chan]   <= avg_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CH_NUM; i++)
            avg_dist[i] = avg_reg[i];
    end

    `UODC_ASSERT_SAME(a_count_bound, frame.valid, sel_count <= CNT_W'(SAMPLES_PER_AVERAGE), "sample count past its set size")

endmodule

// ----- sv/uodc_drive.sv -----
module uodc_drive (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  uodc_pkg::limits_t   limits,
    input  uodc_pkg::dist_arr_t avg_dist,
    output uodc_pkg::decision_t dec
);
    import uodc_pkg::*;

    drive_state_t state_reg, state_next;
    dist_t        v_front, v_side1, v_side2, v_rear;
    logic         front_near, side1_near, side2_near, rear_clear, rear_stop;

    assign v_front    = avg_dist[0];
    assign v_side1    = avg_dist[1];
    assign v_side2    = avg_dist[2];
    assign v_rear     = avg_dist[3];
    assign front_near = (v_front <= limits.front_limit);
    assign side1_near = (v_side1 <= limits.side_limit);
    assign side2_near = (v_side2 <= limits.side_limit);
    assign rear_clear = (v_rear > limits.rear_clear_limit);
    assign rear_stop  = (v_rear <= limits.rear_stop_limit);

    // Next state
    always_comb
    begin
        case (state_reg)
            DS_FORWARD: state_next = front_near ? DS_STOP : DS_FORWARD;
            DS_STOP:
            begin
                if (front_near && rear_clear)
                    state_next = DS_REVERSE;
                else if (!front_near)
                    state_next = DS_FORWARD;
                else
                    state_next = DS_STOP;
            end
            DS_REVERSE: state_next = DS_STOP;
            default:    state_next = DS_STOP;
        endcase
    end

    // Commands
    always_comb
    begin
        dec.motor_cmd = M_NONE;
        dec.servo_cmd = S_NONE;
        case (state_reg)
            DS_FORWARD:
            begin
                if (front_near)
                    dec.motor_cmd = M_STOP;
                else if (!side1_near && !side2_near)
                begin
                    dec.servo_cmd = S_STRAIGHT;
                    dec.motor_cmd = M_FORWARD;
                end
                else if (side1_near)
                    dec.servo_cmd = S_LEFT;
                else
                    dec.servo_cmd = S_RIGHT;
            end
            DS_STOP:
            begin
                if (front_near && rear_clear)
                begin
                    dec.motor_cmd = M_REVERSE;
                    dec.servo_cmd = side1_near ? S_RIGHT : S_LEFT;
                end
                else if (!front_near)
                    dec.motor_cmd = M_FORWARD;
                else
                    dec.motor_cmd = M_STOP;
            end
            DS_REVERSE:
            begin
                if (rear_stop)
                    dec.motor_cmd = M_STOP;
            end
            default:
                dec.motor_cmd = M_STOP;
        endcase
        dec.drive_mode    = state_next;
        dec.obstacle_near = (v_front < limits.front_limit) || side2_near || side1_near
                          || (v_rear < limits.rear_stop_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DS_FORWARD;
        else if (tick)
            state_reg <= state_next;
    end

endmodule

// ----- sv/ultrasonic_obstacle_drive_controller_core.sv -----
// A word accepted is registered in; when it advances, a tick's result is registered in the
// output register and out_valid is set. Link bytes never wait on the output side.
// Throughput: one word per cycle unless a tick meets a full, stalled output.
// Reset (rst_n low, async): parser hunts for a start byte, sums, counts and
// averages clear, drive state goes to forward, limits take their defaults.
`include "ultrasonic_obstacle_drive_controller_core_macros.svh"

module ultrasonic_obstacle_drive_controller_core #(
    parameter int SAMPLES_PER_AVERAGE = uodc_pkg::SAMPLES_DEFAULT,
    parameter int MAX_FRAME_BODY      = uodc_pkg::MAX_BODY_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  uodc_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output uodc_pkg::out_word_t            out_data,
    input  logic                           cfg_wr_en,
    input  logic [uodc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [uodc_pkg::DIST_W-1:0]    cfg_wdata
);
    import uodc_pkg::*;

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    limits_t   limits_reg;

    logic      advance, byte_go, tick_go;
    frame_t    frame;
    dist_arr_t avg_dist;
    decision_t dec;

    // Input stage moves unless a tick meets a full, stalled output
    assign advance  = in_valid_reg && (!in_word_reg.req_type || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign byte_go  = advance && !in_word_reg.req_type;
    assign tick_go  = advance && in_word_reg.req_type;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_data;
    end

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.front_limit      <= FRONT_LIMIT_RST;
            limits_reg.side_limit       <= SIDE_LIMIT_RST;
            limits_reg.rear_clear_limit <= REAR_CLEAR_LIMIT_RST;
            limits_reg.rear_stop_limit  <= REAR_STOP_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_FRONT_LIMIT:      limits_reg.front_limit      <= cfg_wdata;
                CFG_SIDE_LIMIT:       limits_reg.side_limit       <= cfg_wdata;
                CFG_REAR_CLEAR_LIMIT: limits_reg.rear_clear_limit <= cfg_wdata;
                CFG_REAR_STOP_LIMIT:  limits_reg.rear_stop_limit  <= cfg_wdata;
                default:              limits_reg <= limits_reg;
            endcase
        end
    end

    uodc_parser #(
        .MAX_FRAME_BODY (MAX_FRAME_BODY)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (byte_go),
        .rx_byte (in_word_reg.rx_byte),
        .frame   (frame)
    );

    uodc_avg #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .avg_dist (avg_dist)
    );

    uodc_drive u_drive (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick_go),
        .limits   (limits_reg),
        .avg_dist (avg_dist),
        .dec      (dec)
    );

    // Result word
    always_comb
    begin
        out_word_next.motor_cmd     = dec.motor_cmd;
        out_word_next.servo_cmd     = dec.servo_cmd;
        out_word_next.drive_mode    = dec.drive_mode;
        out_word_next.obstacle_near = dec.obstacle_near;
        out_word_next.front_cm      = avg_dist[0];
        out_word_next.side_one_cm   = avg_dist[1];
        out_word_next.side_two_cm   = avg_dist[2];
        out_word_next.rear_cm       = avg_dist[3];
    end

    always_comb
    begin
        if (tick_go)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    `UODC_ASSERT_NEXT(a_tick_gives_word, tick_go, out_valid_reg, "tick left no result word")
    `UODC_ASSERT_NEXT(a_byte_no_word, !out_valid_reg && !tick_go, !out_valid_reg, "result word without a tick")
    `UODC_ASSERT_SAME(a_stall_cause, in_stall, in_word_reg.req_type && out_valid_reg && out_stall, "input held without a blocked tick")

endmodule
